@@ hdl/sgm_pkg.sv @@
// Shared types, constants and codes for the Sobel gradient magnitude unit.
package sgm_pkg;

  // Largest supported line length and frame height.
  localparam int SGM_MAX_WIDTH  = 1024;
  localparam int SGM_MAX_HEIGHT = 4095;

  // Field and register widths.
  localparam int PIX_W     = 8;
  localparam int IN_W      = 3 * PIX_W;
  localparam int CFG_W_W   = 11;
  localparam int CFG_H_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam int ROW_W     = 12;
  localparam int MAG_W     = 11;
  localparam int CMP_W     = 13;

  // Reset values of the configuration registers.
  localparam logic [CFG_W_W-1:0] CFG_W_RESET = 11'd640;
  localparam logic [CFG_H_W-1:0] CFG_H_RESET = 12'd480;
  localparam int MIN_DIM = 3;

  // Luma: floor((299 r + 587 g + 114 b) / 1000), the divide done as a
  // multiply by ceil(2^28 / 1000). The error stays below 1/1000 for every sum.
  localparam int WSUM_W     = 18;
  localparam int PROD_W     = 37;
  localparam int LUMA_WT_R  = 299;
  localparam int LUMA_WT_G  = 587;
  localparam int LUMA_WT_B  = 114;
  localparam int LUMA_RECIP = 268436;
  localparam int LUMA_SHIFT = 28;

  // Sobel sums, squares and the square root radicand.
  localparam int SUM_W = 12;
  localparam int SOB_W = 11;
  localparam int SQ_W  = 20;
  localparam int RAD_W = 2 * MAG_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } sgm_cfg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUMA_SUM,
    ST_LUMA_SCALE,
    ST_SOBEL,
    ST_SQUARE,
    ST_ROOT_START,
    ST_ROOT,
    ST_PUSH
  } sgm_state_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic accept;
    logic luma_sum;
    logic luma_scale;
    logic sobel;
    logic square;
    logic root_start;
    logic push;
  } sgm_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic root_done;
    logic out_free;
  } sgm_status_t;

endpackage

@@ hdl/sgm_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sgm_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
module sgm_isqrt
  import sgm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RAD_W-1:0] radicand_i,
  output logic             done_o,
  output logic [MAG_W-1:0] root_o
);

  localparam int REM_W = MAG_W + 1;
  localparam int TRY_W = REM_W + 2;
  localparam int CNT_W = $clog2(MAG_W);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [RAD_W-1:0] rad_q, rad_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [MAG_W-1:0] root_q, root_d;
  logic [TRY_W-1:0] rem_sh;
  logic [TRY_W-1:0] trial;
  logic [TRY_W-1:0] rem_diff;
  logic             fits;

  // One restoring step: bring down two radicand bits and try a one bit.
  always_comb begin
    rem_sh   = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial    = {1'b0, root_q, 2'b01};
    fits     = (rem_sh >= trial);
    rem_diff = rem_sh - trial;
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    rad_d    = rad_q;
    rem_d    = rem_q;
    root_d   = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(MAG_W - 1);
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[RAD_W-3:0], 2'b00};
      rem_d  = fits ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_d = {root_q[MAG_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  // The last step is under way; the root is final after this edge.
  assign done_o = busy_q && (cnt_q == '0);
  assign root_o = root_q;

endmodule

@@ hdl/sgm_datapath.sv @@
// Datapath: luma, line stores, 3x3 window, Sobel, square root and result register.
module sgm_datapath
  import sgm_pkg::*;
#(
  parameter int MAX_WIDTH = SGM_MAX_WIDTH,
  parameter int COL_W     = $clog2(MAX_WIDTH),
  parameter int OUT_W     = ((2 * MAG_W + ROW_W + COL_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sgm_cmd_t              cmd_i,
  output sgm_status_t           status_o,
  input  logic [IN_W-1:0]       pix_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_W-1:0]      out_data_o,
  output logic                  out_user_o,
  output logic                  out_last_o
);

  // Configuration.
  logic [CFG_W_W-1:0] cfg_w_q;
  logic [CFG_H_W-1:0] cfg_h_q;
  logic [CMP_W-1:0]   w_use;
  logic [CMP_W-1:0]   h_use;

  // Pixel and luma pipeline.
  logic [PIX_W-1:0]  red_q, green_q, blue_q;
  logic [WSUM_W-1:0] wsum_q;
  logic [PROD_W-1:0] prod_q;
  logic [PIX_W-1:0]  luma;

  // Line stores and window.
  logic [PIX_W-1:0] two_back_rd, one_back_rd;
  logic [PIX_W-1:0] win_q [6];
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             col_last, row_last, pix_valid;

  // Sobel and magnitude.
  logic [SUM_W-1:0]        pos_x, neg_x, pos_y, neg_y;
  logic signed [SOB_W-1:0] sx_q, sy_q;
  logic signed [2*SOB_W-1:0] sq_x_full, sq_y_full;
  logic [SQ_W-1:0]         sq_x_q, sq_y_q;
  logic [RAD_W-1:0]        radicand;
  logic                    root_done;
  logic [MAG_W-1:0]        root;

  // Metadata of the pixel in flight.
  logic             meta_valid_q;
  logic [COL_W-1:0] meta_col_q;
  logic [ROW_W-1:0] meta_row_q;
  logic             meta_done_q;

  // Frame maximum and result register.
  logic [MAG_W-1:0] run_max_q, max_new;
  logic             out_valid_q;
  logic [MAG_W-1:0] out_mag_q, out_max_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic             out_user_q, out_last_q;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CFG_W_RESET;
      cfg_h_q <= CFG_H_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  cfg_w_q <= cfg_data_i[CFG_W_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_h_q <= cfg_data_i[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Limits in use, clamped to the legal range.
  always_comb begin
    if (CMP_W'(cfg_w_q) < CMP_W'(MIN_DIM)) begin
      w_use = CMP_W'(MIN_DIM);
    end else if (CMP_W'(cfg_w_q) > CMP_W'(MAX_WIDTH)) begin
      w_use = CMP_W'(MAX_WIDTH);
    end else begin
      w_use = CMP_W'(cfg_w_q);
    end
    if (CMP_W'(cfg_h_q) < CMP_W'(MIN_DIM)) begin
      h_use = CMP_W'(MIN_DIM);
    end else begin
      h_use = CMP_W'(cfg_h_q);
    end
  end

  // Capture the pixel word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      red_q   <= pix_data_i[PIX_W-1:0];
      green_q <= pix_data_i[2*PIX_W-1:PIX_W];
      blue_q  <= pix_data_i[3*PIX_W-1:2*PIX_W];
    end
  end

  // Weighted channel sum, then the scaled product whose top bits are the luma.
  always_ff @(posedge clk_i) begin
    if (cmd_i.luma_sum) begin
      wsum_q <= WSUM_W'(red_q) * WSUM_W'(LUMA_WT_R)
              + WSUM_W'(green_q) * WSUM_W'(LUMA_WT_G)
              + WSUM_W'(blue_q) * WSUM_W'(LUMA_WT_B);
    end
    if (cmd_i.luma_scale) begin
      prod_q <= PROD_W'(wsum_q) * PROD_W'(LUMA_RECIP);
    end
  end

  assign luma = prod_q[LUMA_SHIFT +: PIX_W];

  // Line stores: read at acceptance, written back when the window shifts.
  sgm_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_two_back (
    .clk_i  (clk_i),
    .we_i   (cmd_i.sobel),
    .waddr_i(col_q),
    .wdata_i(one_back_rd),
    .re_i   (cmd_i.accept),
    .raddr_i(col_q),
    .rdata_o(two_back_rd)
  );

  sgm_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_one_back (
    .clk_i  (clk_i),
    .we_i   (cmd_i.sobel),
    .waddr_i(col_q),
    .wdata_i(luma),
    .re_i   (cmd_i.accept),
    .raddr_i(col_q),
    .rdata_o(one_back_rd)
  );

  // Sobel partial sums; the new column is two back, one back and the luma.
  always_comb begin
    pos_x = SUM_W'(two_back_rd) + SUM_W'({one_back_rd, 1'b0}) + SUM_W'(luma);
    neg_x = SUM_W'(win_q[0]) + SUM_W'({win_q[1], 1'b0}) + SUM_W'(win_q[2]);
    pos_y = SUM_W'(win_q[2]) + SUM_W'({win_q[5], 1'b0}) + SUM_W'(luma);
    neg_y = SUM_W'(win_q[0]) + SUM_W'({win_q[3], 1'b0}) + SUM_W'(two_back_rd);
  end

  // Position tests for the pixel in flight.
  assign col_last  = (CMP_W'(col_q) + 1'b1) >= w_use;
  assign row_last  = (CMP_W'(row_q) + 1'b1) >= h_use;
  assign pix_valid = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));

  // Gradients and metadata.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sobel) begin
      sx_q         <= SOB_W'(pos_x - neg_x);
      sy_q         <= SOB_W'(pos_y - neg_y);
      meta_valid_q <= pix_valid;
      meta_col_q   <= pix_valid ? col_q - 1'b1 : '0;
      meta_row_q   <= pix_valid ? row_q - 1'b1 : '0;
      meta_done_q  <= col_last && row_last;
    end
  end

  // Window shift and raster position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.sobel) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= two_back_rd;
      win_q[4] <= one_back_rd;
      win_q[5] <= luma;
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Squares of the gradients.
  assign sq_x_full = sx_q * sx_q;
  assign sq_y_full = sy_q * sy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sq_x_q <= sq_x_full[SQ_W-1:0];
      sq_y_q <= sq_y_full[SQ_W-1:0];
    end
  end

  assign radicand = RAD_W'(sq_x_q) + RAD_W'(sq_y_q);

  sgm_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.root_start),
    .radicand_i(radicand),
    .done_o    (root_done),
    .root_o    (root)
  );

  // Running maximum including this pixel.
  assign max_new = (meta_valid_q && (root > run_max_q)) ? root : run_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_max_q <= '0;
    end else if (cmd_i.push) begin
      run_max_q <= meta_done_q ? '0 : max_new;
    end
  end

  // Result register: the valid flag clears when the word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_mag_q  <= meta_valid_q ? root : '0;
      out_max_q  <= max_new;
      out_col_q  <= meta_col_q;
      out_row_q  <= meta_row_q;
      out_user_q <= meta_valid_q;
      out_last_q <= meta_done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = OUT_W'({out_max_q, out_row_q, out_col_q, out_mag_q});
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

  assign status_o.root_done = root_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

@@ hdl/sgm_ctrl.sv @@
// Sequencer: steps one pixel through the datapath.
module sgm_ctrl
  import sgm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sgm_status_t status_i,
  output sgm_cmd_t    cmd_o
);

  sgm_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LUMA_SUM;
        end
      end
      ST_LUMA_SUM: begin
        cmd_o.luma_sum = 1'b1;
        state_d        = ST_LUMA_SCALE;
      end
      ST_LUMA_SCALE: begin
        cmd_o.luma_scale = 1'b1;
        state_d          = ST_SOBEL;
      end
      ST_SOBEL: begin
        cmd_o.sobel = 1'b1;
        state_d     = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_ROOT_START;
      end
      ST_ROOT_START: begin
        cmd_o.root_start = 1'b1;
        state_d          = ST_ROOT;
      end
      ST_ROOT: begin
        if (status_i.root_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/sobel_gradient_magnitude_unit.sv @@
// Each accepted pixel word steps through accept, luma sum, luma scale, Sobel, squaring,
// root start, the 11-step square root unit and the push; the push waits until the
// result register is free, and a new pixel is taken only after the push. A finished
// result waits in the output register while the next pixel is taken.
// Reset (rst_ni low, asynchronous) clears position, window, frame maximum and control,
// and loads the width and height registers with 640 and 480; line stores are not cleared.
module sobel_gradient_magnitude_unit
  import sgm_pkg::*;
#(
  parameter int MAX_WIDTH = SGM_MAX_WIDTH,
  parameter int COL_W     = $clog2(MAX_WIDTH),
  parameter int OUT_W     = ((2 * MAG_W + ROW_W + COL_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Pixel stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // magnitude, center_column, center_row, frame_max from bit 0 up, zero padded
  output logic [OUT_W-1:0]      m_axis_tdata,
  output logic                  m_axis_tuser,  // window_valid
  output logic                  m_axis_tlast,  // frame_done
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  sgm_cmd_t    cmd;
  sgm_status_t status;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  sgm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  sgm_datapath #(
    .MAX_WIDTH(MAX_WIDTH),
    .COL_W    (COL_W),
    .OUT_W    (OUT_W)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .pix_data_i (s_axis_tdata),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

endmodule

@@ hdl/sgm_checker.sv @@
// Port-level checks for the Sobel gradient magnitude unit, bound to the top level.
module sgm_checker
  import sgm_pkg::*;
#(
  parameter int MAX_WIDTH = SGM_MAX_WIDTH,
  parameter int COL_W     = $clog2(MAX_WIDTH),
  parameter int OUT_W     = ((2 * MAG_W + ROW_W + COL_W + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser,
  input logic             m_axis_tlast
);

  localparam int COL_LO = MAG_W;
  localparam int ROW_LO = COL_LO + COL_W;
  localparam int MAX_LO = ROW_LO + ROW_W;

  logic [MAG_W-1:0] mag, fmax;
  logic [COL_W-1:0] ccol;
  logic [ROW_W-1:0] crow;

  assign mag  = m_axis_tdata[MAG_W-1:0];
  assign ccol = m_axis_tdata[ROW_LO-1:COL_LO];
  assign crow = m_axis_tdata[MAX_LO-1:ROW_LO];
  assign fmax = m_axis_tdata[MAX_LO+MAG_W-1:MAX_LO];

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // Border results carry zero magnitude and position.
  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> mag == '0 && ccol == '0 && crow == '0)
    else $error("border result with nonzero fields");

  // A valid magnitude never exceeds the frame maximum reported with it.
  a_mag_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> mag <= fmax)
    else $error("magnitude above frame maximum");

  // One pixel is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("pixel taken while one is in flight");

endmodule

bind sobel_gradient_magnitude_unit sgm_checker #(
  .MAX_WIDTH(MAX_WIDTH),
  .COL_W    (COL_W),
  .OUT_W    (OUT_W)
) u_sgm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

@@ sim/tb_sobel_gradient_magnitude_unit.sv @@
// Self-checking testbench for the Sobel gradient magnitude unit.
module tb_sobel_gradient_magnitude_unit;
  import sgm_pkg::*;

  localparam int COL_BITS       = $clog2(SGM_MAX_WIDTH);
  localparam int RES_W          = ((2 * MAG_W + ROW_W + COL_BITS + 7) / 8) * 8;
  localparam int COL_LSB        = MAG_W;
  localparam int ROW_LSB        = MAG_W + COL_BITS;
  localparam int FMAX_LSB       = MAG_W + COL_BITS + ROW_W;
  localparam int PAD_LSB        = 2 * MAG_W + COL_BITS + ROW_W;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int TIMEOUT_CYCLES = 1_500_000;
  localparam int RANDOM_PER_MODE = 300;
  localparam int PRINT_CAP      = 40;

  // Register indexes past the end of the register list; writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  // One expected result word, split into its fields.
  typedef struct {
    logic [MAG_W-1:0]    magnitude;
    logic                window_valid;
    logic [COL_BITS-1:0] center_column;
    logic [ROW_W-1:0]    center_row;
    logic [MAG_W-1:0]    frame_max;
    logic                frame_done;
  } mag_result_t;

  // Gradient predictor with its own line stores, window and frame state, plus the
  // queue of magnitudes still owed by the block.
  class sobel_scoreboard;
    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    byte unsigned       line_older[SGM_MAX_WIDTH];
    byte unsigned       line_newer[SGM_MAX_WIDTH];
    byte unsigned       window[6];
    int unsigned        col_pos;
    int unsigned        row_pos;
    int unsigned        peak;
    mag_result_t        owed_q[$];
    int unsigned        errors;
    int unsigned        pixels_in;
    int unsigned        results_seen;
    int unsigned        frames_seen;

    function new();
      width_reg  = CFG_W_RESET;
      height_reg = CFG_H_RESET;
      foreach (line_older[i]) line_older[i] = 0;
      foreach (line_newer[i]) line_newer[i] = 0;
      foreach (window[i]) window[i] = 0;
      col_pos      = 0;
      row_pos      = 0;
      peak         = 0;
      errors       = 0;
      pixels_in    = 0;
      results_seen = 0;
      frames_seen  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = data[CFG_W_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg = data[CFG_H_W-1:0];
        default: ;
      endcase
    endfunction

    // Bit-by-bit search for the largest root whose square fits.
    function int unsigned int_sqrt(int unsigned v);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
        trial = root | (32'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Advance the predictor by one accepted pixel and queue its result.
    function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      int unsigned lim_w;
      int unsigned lim_h;
      int unsigned luma;
      int unsigned slot;
      int unsigned root;
      int unsigned tmp;
      int          nw, n, ne, w, e, sw, s, se, gx, gy;
      logic        inner;
      mag_result_t res;

      lim_w = (width_reg < MIN_DIM) ? MIN_DIM :
              (width_reg > SGM_MAX_WIDTH) ? SGM_MAX_WIDTH : int'(width_reg);
      lim_h = (height_reg < MIN_DIM) ? MIN_DIM : int'(height_reg);
      // Luma weights are exact thousandths, truncated.
      luma = (299 * int'(red) + 587 * int'(green) + 114 * int'(blue)) / 1000;
      slot = col_pos % SGM_MAX_WIDTH;

      // Right column comes from the line stores and the new pixel.
      ne = line_older[slot];
      e  = line_newer[slot];
      se = luma;
      nw = window[0];
      w  = window[1];
      sw = window[2];
      n  = window[3];
      s  = window[5];
      gx = (ne + 2 * e + se) - (nw + 2 * w + sw);
      gy = (sw + 2 * s + se) - (nw + 2 * n + ne);

      inner = (row_pos >= 2) && (col_pos >= 2);
      res.magnitude     = '0;
      res.window_valid  = inner;
      res.center_column = '0;
      res.center_row    = '0;
      if (inner) begin
        root = int_sqrt(gx * gx + gy * gy);
        if (root > peak) peak = root;
        res.magnitude     = root[MAG_W-1:0];
        tmp               = col_pos - 1;
        res.center_column = tmp[COL_BITS-1:0];
        tmp               = row_pos - 1;
        res.center_row    = tmp[ROW_W-1:0];
      end
      res.frame_max  = peak[MAG_W-1:0];
      res.frame_done = (col_pos + 1 >= lim_w) && (row_pos + 1 >= lim_h);

      // Slide the window one column and refresh the line stores.
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = ne[7:0];
      window[4] = e[7:0];
      window[5] = luma[7:0];
      line_older[slot] = e[7:0];
      line_newer[slot] = luma[7:0];

      // Position of the next pixel; the frame maximum restarts with a new frame.
      if (col_pos + 1 >= lim_w) begin
        col_pos = 0;
        if (row_pos + 1 >= lim_h) begin
          row_pos = 0;
          peak    = 0;
        end else begin
          row_pos = row_pos + 1;
        end
      end else begin
        col_pos = col_pos + 1;
      end

      owed_q.push_back(res);
      pixels_in++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one result word with the oldest owed result.
    task check_result(logic [RES_W-1:0] data, logic user, logic last);
      mag_result_t exp_r;
      results_seen++;
      if (owed_q.size() == 0) begin
        report($sformatf("result word with no pixel outstanding, data=%h", data));
        return;
      end
      exp_r = owed_q.pop_front();
      if (exp_r.frame_done) frames_seen++;
      if (data[MAG_W-1:0] !== exp_r.magnitude)
        report($sformatf("result %0d magnitude: got %0d, want %0d", results_seen,
                         data[MAG_W-1:0], exp_r.magnitude));
      if (user !== exp_r.window_valid)
        report($sformatf("result %0d window_valid: got %b, want %b", results_seen,
                         user, exp_r.window_valid));
      if (data[COL_LSB +: COL_BITS] !== exp_r.center_column)
        report($sformatf("result %0d center_column: got %0d, want %0d", results_seen,
                         data[COL_LSB +: COL_BITS], exp_r.center_column));
      if (data[ROW_LSB +: ROW_W] !== exp_r.center_row)
        report($sformatf("result %0d center_row: got %0d, want %0d", results_seen,
                         data[ROW_LSB +: ROW_W], exp_r.center_row));
      if (data[FMAX_LSB +: MAG_W] !== exp_r.frame_max)
        report($sformatf("result %0d frame_max: got %0d, want %0d", results_seen,
                         data[FMAX_LSB +: MAG_W], exp_r.frame_max));
      if (last !== exp_r.frame_done)
        report($sformatf("result %0d frame_done: got %b, want %b", results_seen,
                         last, exp_r.frame_done));
      if (data[RES_W-1:PAD_LSB] !== '0)
        report($sformatf("result %0d padding bits not zero: %h", results_seen,
                         data[RES_W-1:PAD_LSB]));
    endtask

    task check_drained();
      if (owed_q.size() != 0)
        report($sformatf("%0d results never arrived", owed_q.size()));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [RES_W-1:0]      m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sobel_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     hold_left;
  int unsigned     cfg_writes;

  sobel_gradient_magnitude_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left     = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every accepted result word is checked against the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Hard stop in case the block hangs.
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one pixel word after a random gap and wait until it is taken.
  task automatic push_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pixel(red, green, blue);
    @(negedge clk_i);
  endtask

  // Mix of full-range noise, saturated channels and gray levels.
  task automatic push_random_pixel();
    logic [7:0]  red, green, blue;
    int unsigned style;
    style = $urandom_range(3);
    case (style)
      2: begin
        red   = $urandom_range(1) ? 8'hFF : 8'h00;
        green = $urandom_range(1) ? 8'hFF : 8'h00;
        blue  = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      3: begin
        red   = 8'($urandom);
        green = red;
        blue  = red;
      end
      default: begin
        red   = 8'($urandom);
        green = 8'($urandom);
        blue  = 8'($urandom);
      end
    endcase
    push_pixel(red, green, blue);
  endtask

  // Send pixels until the predictor sits at the start of a frame.
  task automatic finish_frame();
    while (sb.col_pos != 0 || sb.row_pos != 0) push_random_pixel();
  endtask

  task automatic run_frames(input int unsigned count);
    repeat (count) begin
      push_random_pixel();
      finish_frame();
    end
  endtask

  // Write one register; the valid is lowered only after the last write of a group.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data, input logic lower);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    if (lower) cfg_valid_i <= 1'b0;
  endtask

  // Stop offering pixels and let every owed result come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w_data,
                              input logic [CFG_DATA_W-1:0] h_data);
    wait_for_results();
    write_register(CFG_IMAGE_WIDTH, w_data, 1'b0);
    write_register(CFG_IMAGE_HEIGHT, h_data, 1'b1);
  endtask

  // Random geometries, mostly small, with the odd clamped value.
  task automatic random_block();
    int unsigned start;
    logic [CFG_DATA_W-1:0] w_data, h_data;
    start = sb.pixels_in;
    while (sb.pixels_in - start < RANDOM_PER_MODE) begin
      if ($urandom_range(9) == 0) w_data = CFG_DATA_W'($urandom_range(2));
      else if ($urandom_range(7) == 0) w_data = CFG_DATA_W'($urandom_range(48, 13));
      else w_data = CFG_DATA_W'($urandom_range(12, 3));
      if ($urandom_range(9) == 0) h_data = CFG_DATA_W'($urandom_range(2));
      else h_data = CFG_DATA_W'($urandom_range(6, 3));
      set_geometry(w_data, h_data);
      run_frames($urandom_range(3, 1));
    end
  endtask

  // Main sequence.
  initial begin
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_IMAGE_WIDTH;
    cfg_data_i    = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    cfg_writes    = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Smallest frame via clamped values, then writes to unused indexes that must not stick.
    write_register(CFG_IMAGE_WIDTH, 12'd0, 1'b0);
    write_register(CFG_IMAGE_HEIGHT, 12'd2, 1'b0);
    write_register(CFG_IDX_SPARE_LO, 12'hFFF, 1'b0);
    write_register(CFG_IDX_SPARE_HI, 12'hFFF, 1'b1);

    // Steep positive gradient: dark left and top, white right and bottom.
    push_pixel(8'h00, 8'h00, 8'h00); push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'h00, 8'h00, 8'h00); push_pixel(8'h80, 8'h80, 8'h80);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'h00, 8'h00, 8'h00); push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    // Mirrored frame with pure channels, giving a negative horizontal gradient.
    push_pixel(8'hFF, 8'h00, 8'h00); push_pixel(8'h00, 8'hFF, 8'h00);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'h00, 8'h00, 8'hFF); push_pixel(8'hFF, 8'hFF, 8'h00);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF); push_pixel(8'h00, 8'hFF, 8'hFF);
    push_pixel(8'h00, 8'h00, 8'h00);

    // Sender mostly steady, receiver stalling often.
    send_idle_pct = 34;
    recv_idle_pct = 79;
    random_block();

    // Roles swapped.
    send_idle_pct = 79;
    recv_idle_pct = 34;
    random_block();

    // Width narrowed and height lowered in the middle of a tall frame.
    set_geometry(12'd8, 12'hFFF);
    repeat (28) push_random_pixel();
    set_geometry(12'd5, 12'd6);
    finish_frame();
    // Height dropped below the current row, so the frame ends with this row.
    set_geometry(12'd3, 12'hFFF);
    repeat (15) push_random_pixel();
    wait_for_results();
    write_register(CFG_IMAGE_HEIGHT, 12'd3, 1'b1);
    finish_frame();

    // No idling; a long output hold-off backs the block up into its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_geometry(12'd7, 12'd5);
    hold_left = HOLD_CYCLES;
    run_frames(2);
    random_block();

    wait_for_results();
    sb.check_drained();
    $display("Checked %0d result words for %0d pixels over %0d frames, %0d register writes.",
             sb.results_seen, sb.pixels_in, sb.frames_seen, cfg_writes);
    $display("Lines of 3 to 48 pixels, clamped and unused registers, mid-frame changes.");
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
